### hw/rtl/gpeh_pkg.sv
// Shared types, constants and compare helpers for the gamepad edge and hysteresis block.
`default_nettype none

package gpeh_pkg;

	// Fixed field widths
	localparam int BTN_W      = 16;
	localparam int BTN_IDX_W  = 4;
	localparam int SAMPLE_W   = 16;
	localparam int THR_W      = 16;
	localparam int AXES       = 4;
	localparam int STICK_DIRS = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int PAD_IDX_IN_W = 3;

	// Full scale in Q1.15 (1.0)
	localparam logic [THR_W-1:0] FULL_SCALE = 16'h8000;

	// Item commands
	typedef enum logic {
		CMD_POLL  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADZONE = 2'd0,
		CFG_PRESS    = 2'd1,
		CFG_RELEASE  = 2'd2
	} cfg_idx_t;

	// Effective thresholds after clamping
	typedef struct packed {
		logic [THR_W-1:0] dz;
		logic [THR_W-1:0] pt;
		logic [THR_W-1:0] rt;
	} thr_t;

	// Per-pad stored state
	typedef struct packed {
		logic [BTN_W-1:0]      held;
		logic [STICK_DIRS-1:0] stick;
	} pad_state_t;

	// Exact compare of num/den against t/32768, where den is 32768 for a
	// negative sample and 32767 otherwise. Both sides are scaled by 32768 * den.
	function automatic logic [1:0] mag_cmp(
		input logic [SAMPLE_W-1:0] num,
		input logic                neg,
		input logic [THR_W-1:0]    t
	);
		logic [30:0] lhs;
		logic [30:0] rhs;
		logic [1:0]  res;
		lhs = {num, 15'b0};
		rhs = neg ? {t, 15'b0} : ({t, 15'b0} - {15'b0, t});
		// res[1]: num/den >= t, res[0]: num/den <= t
		res = {lhs >= rhs, lhs <= rhs};
		return res;
	endfunction

	// Index of the lowest set bit; all ones when nothing is set
	function automatic logic [BTN_IDX_W-1:0] lowest_set(input logic [BTN_W-1:0] v);
		logic [BTN_IDX_W-1:0] idx;
		idx = BTN_IDX_W'(BTN_W - 1);
		for (int b = BTN_W - 1; b >= 0; b--) begin
			if (v[b]) begin
				idx = BTN_IDX_W'(b);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/gpeh_pad_state.sv
// Per-pad state registers: held buttons and stick direction bits for each slot.
`default_nettype none

module gpeh_pad_state #(
	parameter int PAD_SLOTS = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic [(PAD_SLOTS > 1 ? $clog2(PAD_SLOTS) : 1)-1:0] rd_idx,
	output      gpeh_pkg::pad_state_t                    rd_data,
	input  wire logic                                    wr_en,
	input  wire logic [(PAD_SLOTS > 1 ? $clog2(PAD_SLOTS) : 1)-1:0] wr_idx,
	input  wire gpeh_pkg::pad_state_t                    wr_data
);

	gpeh_pkg::pad_state_t slot_q [PAD_SLOTS];

	// Read the addressed slot; callers ignore out-of-range slots.
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < PAD_SLOTS; i++) begin
			if (rd_idx == $bits(rd_idx)'(i)) begin
				rd_data = slot_q[i];
			end
		end
	end

	// Write one slot per cycle while wr_en is high; reset clears every slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAD_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < PAD_SLOTS; i++) begin
				if (wr_idx == $bits(wr_idx)'(i)) begin
					slot_q[i] <= wr_data;
				end
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/gpeh_stick_eval.sv
// Stick direction evaluation: deadzone, press and release hysteresis for eight directions.
`default_nettype none

module gpeh_stick_eval (
	input  wire logic [gpeh_pkg::AXES-1:0][gpeh_pkg::SAMPLE_W-1:0] samples,
	input  wire gpeh_pkg::thr_t                                     thr,
	input  wire logic [gpeh_pkg::STICK_DIRS-1:0]                    dir_was,
	output      logic [gpeh_pkg::STICK_DIRS-1:0]                    dir_now
);

	// Each axis feeds two directions: negative side at 2a, positive side at 2a+1.
	for (genvar a = 0; a < gpeh_pkg::AXES; a++) begin : g_axis
		logic                          neg;
		logic [gpeh_pkg::SAMPLE_W-1:0] num;
		logic [1:0]                    dz_cmp;
		logic [1:0]                    pt_cmp;
		logic [1:0]                    rt_cmp;
		logic                          outside;
		logic [1:0]                    active;
		logic [1:0]                    ge;
		logic [1:0]                    le;

		// Magnitude numerator: the full negative range maps to 32768.
		assign neg = samples[a][gpeh_pkg::SAMPLE_W-1];
		assign num = neg ? (~samples[a] + 1'b1) : samples[a];

		assign dz_cmp  = gpeh_pkg::mag_cmp(num, neg, thr.dz);
		assign pt_cmp  = gpeh_pkg::mag_cmp(num, neg, thr.pt);
		assign rt_cmp  = gpeh_pkg::mag_cmp(num, neg, thr.rt);
		assign outside = !dz_cmp[0];
		assign active  = {!neg && outside, neg && outside};

		// A direction with zero magnitude presses only at a zero threshold
		// and always releases.
		for (genvar s = 0; s < 2; s++) begin : g_side
			assign ge[s] = active[s] ? pt_cmp[1] : (thr.pt == '0);
			assign le[s] = active[s] ? rt_cmp[0] : 1'b1;
			assign dir_now[2*a+s] = dir_was[2*a+s] ? !le[s] : ge[s];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/gamepad_edge_hysteresis.sv
// Top level: gamepad button edge detection and stick direction hysteresis.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | command, pad_index, frame_start, button_mask,
//          |                       | left_x, left_y, right_x, right_y
//  out     | out_valid / out_ready | buttons_*, stick_*, frame_first_*
//  cfg     | cfg_wr_en             | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// waits in the input register until its result is loaded into the result register.
// Per-pad state is read and written in the same stage, so items for the same
// pad may follow each other back to back.
// Reset clears all pad state and the frame latch and returns the configuration
// registers to their reset values.
// A stalled output holds the result and the input register; in_ready drops only
// while both are full and out_ready is low.
`default_nettype none

module gamepad_edge_hysteresis #(
	parameter int PAD_SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [gpeh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gpeh_pkg::THR_W-1:0]     cfg_data,
	// Input items
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        command,
	input  wire logic [gpeh_pkg::PAD_IDX_IN_W-1:0] pad_index,
	input  wire logic        frame_start,
	input  wire logic [gpeh_pkg::BTN_W-1:0]        button_mask,
	input  wire logic signed [gpeh_pkg::SAMPLE_W-1:0] left_x,
	input  wire logic signed [gpeh_pkg::SAMPLE_W-1:0] left_y,
	input  wire logic signed [gpeh_pkg::SAMPLE_W-1:0] right_x,
	input  wire logic signed [gpeh_pkg::SAMPLE_W-1:0] right_y,
	// Result items
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [gpeh_pkg::BTN_W-1:0]      buttons_held,
	output      logic [gpeh_pkg::BTN_W-1:0]      buttons_pressed,
	output      logic [gpeh_pkg::BTN_W-1:0]      buttons_released,
	output      logic [gpeh_pkg::STICK_DIRS-1:0] stick_held,
	output      logic [gpeh_pkg::STICK_DIRS-1:0] stick_down_edge,
	output      logic [gpeh_pkg::STICK_DIRS-1:0] stick_up_edge,
	output      logic [gpeh_pkg::BTN_IDX_W-1:0]  frame_first_button,
	output      logic        frame_first_valid
);

	localparam int PIW = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;

	// Configuration registers
	logic [gpeh_pkg::THR_W-1:0] deadzone_q;
	logic [gpeh_pkg::THR_W-1:0] press_q;
	logic [gpeh_pkg::THR_W-1:0] release_q;

	// Input stage
	logic                                             valid_s1;
	logic                                             command_s1;
	logic [gpeh_pkg::PAD_IDX_IN_W-1:0]                pad_index_s1;
	logic                                             frame_start_s1;
	logic [gpeh_pkg::BTN_W-1:0]                       button_mask_s1;
	logic [gpeh_pkg::AXES-1:0][gpeh_pkg::SAMPLE_W-1:0] samples_s1;

	// Frame latch
	logic                           seen_q;
	logic [gpeh_pkg::BTN_IDX_W-1:0] latch_q;

	// Result register
	logic                              out_valid_q;
	logic [gpeh_pkg::BTN_W-1:0]        held_q;
	logic [gpeh_pkg::BTN_W-1:0]        pressed_q;
	logic [gpeh_pkg::BTN_W-1:0]        released_q;
	logic [gpeh_pkg::STICK_DIRS-1:0]   sheld_q;
	logic [gpeh_pkg::STICK_DIRS-1:0]   spressed_q;
	logic [gpeh_pkg::STICK_DIRS-1:0]   sreleased_q;

	// Combinational work of the input stage
	logic                            advance;
	logic                            fire;
	logic                            pad_ok;
	logic                            poll;
	logic [PIW-1:0]                  pad_idx;
	gpeh_pkg::thr_t                  thr;
	logic [gpeh_pkg::THR_W-1:0]      pt_eff;
	gpeh_pkg::pad_state_t            prev_state;
	gpeh_pkg::pad_state_t            next_state;
	logic [gpeh_pkg::STICK_DIRS-1:0] dir_now;
	logic [gpeh_pkg::BTN_W-1:0]      held_d;
	logic [gpeh_pkg::BTN_W-1:0]      pressed_d;
	logic [gpeh_pkg::BTN_W-1:0]      released_d;
	logic [gpeh_pkg::STICK_DIRS-1:0] sheld_d;
	logic [gpeh_pkg::STICK_DIRS-1:0] spressed_d;
	logic [gpeh_pkg::STICK_DIRS-1:0] sreleased_d;
	logic                            seen_base;
	logic [gpeh_pkg::BTN_IDX_W-1:0]  latch_base;
	logic                            take_first;
	logic                            seen_d;
	logic [gpeh_pkg::BTN_IDX_W-1:0]  latch_d;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= 16'd4915;
			press_q    <= 16'd16384;
			release_q  <= 16'd13107;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gpeh_pkg::CFG_DEADZONE: deadzone_q <= cfg_data;
				gpeh_pkg::CFG_PRESS:    press_q    <= cfg_data;
				gpeh_pkg::CFG_RELEASE:  release_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective thresholds: saturate at full scale, release capped at press.
	assign pt_eff = (press_q > gpeh_pkg::FULL_SCALE) ? gpeh_pkg::FULL_SCALE : press_q;
	assign thr.dz = (deadzone_q > gpeh_pkg::FULL_SCALE) ? gpeh_pkg::FULL_SCALE : deadzone_q;
	assign thr.pt = pt_eff;
	assign thr.rt = (release_q > pt_eff) ? pt_eff : release_q;

	// Pipeline flow control
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1     <= command;
			pad_index_s1   <= pad_index;
			frame_start_s1 <= frame_start;
			button_mask_s1 <= button_mask;
			samples_s1     <= {right_y, right_x, left_y, left_x};
		end
	end

	// Pad slot lookup
	assign pad_ok  = 32'(pad_index_s1) < PAD_SLOTS;
	assign pad_idx = PIW'(pad_index_s1);
	assign poll    = pad_ok && (command_s1 == gpeh_pkg::CMD_POLL);

	gpeh_pad_state #(
		.PAD_SLOTS (PAD_SLOTS)
	) u_pad_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (pad_idx),
		.rd_data (prev_state),
		.wr_en   (fire && pad_ok),
		.wr_idx  (pad_idx),
		.wr_data (next_state)
	);

	gpeh_stick_eval u_stick_eval (
		.samples (samples_s1),
		.thr     (thr),
		.dir_was (prev_state.stick),
		.dir_now (dir_now)
	);

	// Button edges and stick edges; a clear or an unused slot reports zeros.
	always_comb begin
		held_d      = '0;
		pressed_d   = '0;
		released_d  = '0;
		sheld_d     = '0;
		spressed_d  = '0;
		sreleased_d = '0;
		if (poll) begin
			held_d      = button_mask_s1;
			pressed_d   = button_mask_s1 & ~prev_state.held;
			released_d  = ~button_mask_s1 & prev_state.held;
			sheld_d     = dir_now;
			spressed_d  = dir_now & ~prev_state.stick;
			sreleased_d = prev_state.stick & ~dir_now;
		end
		next_state.held  = held_d;
		next_state.stick = sheld_d;
	end

	// Frame latch: frame_start clears it before this item is considered.
	assign seen_base  = frame_start_s1 ? 1'b0 : seen_q;
	assign latch_base = frame_start_s1 ? '0 : latch_q;
	assign take_first = !seen_base && (pressed_d != '0);
	assign seen_d     = seen_base || take_first;
	assign latch_d    = take_first ? gpeh_pkg::lowest_set(pressed_d) : latch_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			latch_q <= '0;
		end else if (fire) begin
			seen_q  <= seen_d;
			latch_q <= latch_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held_q      <= held_d;
			pressed_q   <= pressed_d;
			released_q  <= released_d;
			sheld_q     <= sheld_d;
			spressed_q  <= spressed_d;
			sreleased_q <= sreleased_d;
		end
	end

	// Output ports
	assign out_valid          = out_valid_q;
	assign buttons_held       = held_q;
	assign buttons_pressed    = pressed_q;
	assign buttons_released   = released_q;
	assign stick_held         = sheld_q;
	assign stick_down_edge    = spressed_q;
	assign stick_up_edge      = sreleased_q;
	assign frame_first_button = latch_q;
	assign frame_first_valid  = seen_q;

endmodule

`default_nettype wire

### hw/rtl/gpeh_checker.sv
// Port-level checks for the gamepad edge and hysteresis block, bound to its top level.
`default_nettype none

module gpeh_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [gpeh_pkg::BTN_W-1:0]      buttons_held,
	input wire logic [gpeh_pkg::BTN_W-1:0]      buttons_pressed,
	input wire logic [gpeh_pkg::BTN_W-1:0]      buttons_released,
	input wire logic [gpeh_pkg::STICK_DIRS-1:0] stick_held,
	input wire logic [gpeh_pkg::STICK_DIRS-1:0] stick_down_edge,
	input wire logic [gpeh_pkg::STICK_DIRS-1:0] stick_up_edge,
	input wire logic [gpeh_pkg::BTN_IDX_W-1:0]  frame_first_button,
	input wire logic frame_first_valid
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(buttons_held)
			&& $stable(buttons_pressed) && $stable(stick_held))
		else $error("result changed while stalled");

	// A button or direction cannot both go down and come up in one item.
	a_edge_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((buttons_pressed & buttons_released) == '0)
			&& ((stick_down_edge & stick_up_edge) == '0))
		else $error("pressed and released overlap");

	// Newly pressed implies held, newly released implies not held.
	a_edge_vs_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((buttons_pressed & ~buttons_held) == '0)
			&& ((buttons_released & buttons_held) == '0)
			&& ((stick_down_edge & ~stick_held) == '0)
			&& ((stick_up_edge & stick_held) == '0))
		else $error("edge bits disagree with held bits");

	// Without a latched button the reported index is zero.
	a_first_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_first_valid |-> frame_first_button == '0)
		else $error("frame first button set without a latched button");

endmodule

bind gamepad_edge_hysteresis gpeh_checker u_gpeh_checker (.*);

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for the gamepad edge and stick hysteresis block, with directed and random items.
module testbench;

	localparam int PADS            = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 60;
	localparam int RANDOM_ITEMS    = 2000;
	localparam int REPROGRAM_EVERY = 400;

	localparam logic [gpeh_pkg::THR_W-1:0] DEADZONE_RESET = 16'd4915;
	localparam logic [gpeh_pkg::THR_W-1:0] PRESS_RESET    = 16'd16384;
	localparam logic [gpeh_pkg::THR_W-1:0] RELEASE_RESET  = 16'd13107;

	// One poll item; axis 0..3 are left_x, left_y, right_x, right_y.
	typedef struct packed {
		gpeh_pkg::cmd_t                                    cmd;
		logic [gpeh_pkg::PAD_IDX_IN_W-1:0]                 pad;
		logic                                              fstart;
		logic [gpeh_pkg::BTN_W-1:0]                        mask;
		logic [gpeh_pkg::AXES-1:0][gpeh_pkg::SAMPLE_W-1:0] axis;
	} poll_t;

	// One pad report as the block returns it.
	typedef struct packed {
		logic [gpeh_pkg::BTN_W-1:0]      held;
		logic [gpeh_pkg::BTN_W-1:0]      pressed;
		logic [gpeh_pkg::BTN_W-1:0]      released;
		logic [gpeh_pkg::STICK_DIRS-1:0] s_held;
		logic [gpeh_pkg::STICK_DIRS-1:0] s_pressed;
		logic [gpeh_pkg::STICK_DIRS-1:0] s_released;
		logic [gpeh_pkg::BTN_IDX_W-1:0]  first_btn;
		logic                            first_vld;
	} report_t;

	// A magnitude as an exact ratio num / den.
	typedef struct {
		longint unsigned num;
		longint unsigned den;
	} mag_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	gpeh_pkg::cfg_idx_t cfg_index;
	logic [gpeh_pkg::THR_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	gpeh_pkg::cmd_t command;
	logic [gpeh_pkg::PAD_IDX_IN_W-1:0] pad_index;
	logic frame_start;
	logic [gpeh_pkg::BTN_W-1:0] button_mask;
	logic signed [gpeh_pkg::SAMPLE_W-1:0] left_x;
	logic signed [gpeh_pkg::SAMPLE_W-1:0] left_y;
	logic signed [gpeh_pkg::SAMPLE_W-1:0] right_x;
	logic signed [gpeh_pkg::SAMPLE_W-1:0] right_y;
	logic out_valid;
	logic out_ready;
	logic [gpeh_pkg::BTN_W-1:0] buttons_held;
	logic [gpeh_pkg::BTN_W-1:0] buttons_pressed;
	logic [gpeh_pkg::BTN_W-1:0] buttons_released;
	logic [gpeh_pkg::STICK_DIRS-1:0] stick_held;
	logic [gpeh_pkg::STICK_DIRS-1:0] stick_down_edge;
	logic [gpeh_pkg::STICK_DIRS-1:0] stick_up_edge;
	logic [gpeh_pkg::BTN_IDX_W-1:0] frame_first_button;
	logic frame_first_valid;

	// Shared bench state.
	report_t expected_reports[$];
	int error_count;
	int cycle_count;
	bit hold_off_req;
	bit no_idle;

	// Predicted block state and configuration.
	logic [gpeh_pkg::BTN_W-1:0]      pad_held_state [PADS];
	logic [gpeh_pkg::STICK_DIRS-1:0] pad_stick_state [PADS];
	logic [gpeh_pkg::BTN_IDX_W-1:0]  frame_first_btn;
	logic                            frame_first_seen;
	logic [gpeh_pkg::THR_W-1:0]      reg_deadzone;
	logic [gpeh_pkg::THR_W-1:0]      reg_press;
	logic [gpeh_pkg::THR_W-1:0]      reg_release;

	// Masks last sent per pad, so that random items mostly flip at most one button.
	logic [gpeh_pkg::BTN_W-1:0] sent_mask [PADS];

	gamepad_edge_hysteresis u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.pad_index          (pad_index),
		.frame_start        (frame_start),
		.button_mask        (button_mask),
		.left_x             (left_x),
		.left_y             (left_y),
		.right_x            (right_x),
		.right_y            (right_y),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.buttons_held       (buttons_held),
		.buttons_pressed    (buttons_pressed),
		.buttons_released   (buttons_released),
		.stick_held         (stick_held),
		.stick_down_edge    (stick_down_edge),
		.stick_up_edge      (stick_up_edge),
		.frame_first_button (frame_first_button),
		.frame_first_valid  (frame_first_valid)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter with a hard limit on the run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// True when the ratio m is at or above the Q1.15 fraction t.
	function automatic bit ratio_ge(mag_t m, logic [gpeh_pkg::THR_W-1:0] t);
		return m.num * 64'd32768 >= 64'(t) * m.den;
	endfunction

	// True when the ratio m is at or below the Q1.15 fraction t.
	function automatic bit ratio_le(mag_t m, logic [gpeh_pkg::THR_W-1:0] t);
		return m.num * 64'd32768 <= 64'(t) * m.den;
	endfunction

	// Split one raw axis sample into its negative-side and positive-side magnitudes.
	function automatic void split_axis(input logic [gpeh_pkg::SAMPLE_W-1:0] raw,
		input logic [gpeh_pkg::THR_W-1:0] dz, output mag_t neg_side, output mag_t pos_side);
		mag_t m;
		neg_side.num = 0;
		neg_side.den = 32768;
		pos_side = neg_side;
		if (raw[gpeh_pkg::SAMPLE_W-1]) begin
			m.num = 65536 - raw;
			m.den = 32768;
		end else begin
			m.num = raw;
			m.den = 32767;
		end
		if (!ratio_le(m, dz)) begin
			if (raw[gpeh_pkg::SAMPLE_W-1]) begin
				neg_side = m;
			end else begin
				pos_side = m;
			end
		end
	endfunction

	// Work out the report for one accepted item and advance the predicted pad state.
	function automatic report_t compute_pad_report(poll_t p);
		report_t r;
		logic [gpeh_pkg::THR_W-1:0] dz;
		logic [gpeh_pkg::THR_W-1:0] pt;
		logic [gpeh_pkg::THR_W-1:0] rt;
		logic [gpeh_pkg::BTN_W-1:0] prev;
		logic [gpeh_pkg::STICK_DIRS-1:0] was;
		mag_t mags [gpeh_pkg::STICK_DIRS];
		bit went_down;
		int b;
		r = '0;
		if (p.fstart) begin
			frame_first_seen = 1'b0;
			frame_first_btn = '0;
		end
		// Thresholds saturate at full scale, and release never exceeds press.
		dz = (reg_deadzone > gpeh_pkg::FULL_SCALE) ? gpeh_pkg::FULL_SCALE : reg_deadzone;
		pt = (reg_press > gpeh_pkg::FULL_SCALE) ? gpeh_pkg::FULL_SCALE : reg_press;
		rt = (reg_release > pt) ? pt : reg_release;
		if (p.cmd == gpeh_pkg::CMD_CLEAR) begin
			pad_held_state[p.pad] = '0;
			pad_stick_state[p.pad] = '0;
		end else begin
			prev = pad_held_state[p.pad];
			was = pad_stick_state[p.pad];
			r.held = p.mask;
			r.pressed = p.mask & ~prev;
			r.released = ~p.mask & prev;
			pad_held_state[p.pad] = p.mask;
			// The first pad in the frame with a new press latches its lowest button.
			if (!frame_first_seen && r.pressed != '0) begin
				b = 0;
				while (b < gpeh_pkg::BTN_W - 1 && !r.pressed[b]) b++;
				frame_first_btn = gpeh_pkg::BTN_IDX_W'(b);
				frame_first_seen = 1'b1;
			end
			// Each axis gives the (left or up, right or down) pair of directions.
			for (int a = 0; a < gpeh_pkg::AXES; a++) begin
				split_axis(p.axis[a], dz, mags[2*a], mags[2*a+1]);
			end
			for (int k = 0; k < gpeh_pkg::STICK_DIRS; k++) begin
				went_down = was[k] ? !ratio_le(mags[k], rt) : ratio_ge(mags[k], pt);
				r.s_held[k] = went_down;
				r.s_pressed[k] = went_down && !was[k];
				r.s_released[k] = was[k] && !went_down;
			end
			pad_stick_state[p.pad] = r.s_held;
		end
		r.first_vld = frame_first_seen;
		r.first_btn = frame_first_seen ? frame_first_btn : '0;
		return r;
	endfunction

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// A register value: mostly in range, with the extremes and values past full scale.
	function automatic logic [gpeh_pkg::THR_W-1:0] random_level(int typical_max);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return gpeh_pkg::FULL_SCALE;
		end else if (r == 2) begin
			return gpeh_pkg::THR_W'($urandom_range(32769, 65535));
		end
		return gpeh_pkg::THR_W'($urandom_range(0, typical_max));
	endfunction

	// A stick sample: extremes, values close to one of the thresholds, or anything.
	function automatic logic [gpeh_pkg::SAMPLE_W-1:0] random_sample();
		int r;
		int t;
		int v;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				3: v = -1;
				default: v = 1;
			endcase
		end else if (r < 6) begin
			case ($urandom_range(0, 2))
				0: t = reg_deadzone;
				1: t = reg_press;
				default: t = reg_release;
			endcase
			if (t > 32768) t = 32768;
			v = t + $urandom_range(0, 6) - 3;
			if ($urandom_range(0, 1)) v = -v;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
		end else begin
			v = $urandom;
		end
		return gpeh_pkg::SAMPLE_W'(v);
	endfunction

	// A directed item from plain values.
	function automatic poll_t make_poll(gpeh_pkg::cmd_t cmd, int pad, bit fs,
		logic [gpeh_pkg::BTN_W-1:0] mask, int lx, int ly, int rx, int ry);
		poll_t p;
		p.cmd = cmd;
		p.pad = gpeh_pkg::PAD_IDX_IN_W'(pad);
		p.fstart = fs;
		p.mask = mask;
		p.axis[0] = gpeh_pkg::SAMPLE_W'(lx);
		p.axis[1] = gpeh_pkg::SAMPLE_W'(ly);
		p.axis[2] = gpeh_pkg::SAMPLE_W'(rx);
		p.axis[3] = gpeh_pkg::SAMPLE_W'(ry);
		return p;
	endfunction

	// A random item for one pad; the button mask mostly follows the previous one.
	function automatic poll_t random_poll(int pad, bit fs);
		poll_t p;
		int r;
		p.cmd = ($urandom_range(0, 29) == 0) ? gpeh_pkg::CMD_CLEAR : gpeh_pkg::CMD_POLL;
		p.pad = gpeh_pkg::PAD_IDX_IN_W'(pad);
		p.fstart = fs;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			p.mask = sent_mask[pad]
				^ (gpeh_pkg::BTN_W'(1) << $urandom_range(0, gpeh_pkg::BTN_W - 1));
		end else if (r < 7) begin
			p.mask = sent_mask[pad];
		end else if (r < 9) begin
			p.mask = gpeh_pkg::BTN_W'($urandom);
		end else begin
			p.mask = $urandom_range(0, 1) ? '1 : '0;
		end
		sent_mask[pad] = p.mask;
		for (int a = 0; a < gpeh_pkg::AXES; a++) begin
			p.axis[a] = random_sample();
		end
		return p;
	endfunction

	// Offer one item after a random gap and record its report once it is accepted.
	task automatic send_poll(input poll_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= it.cmd;
		pad_index <= it.pad;
		frame_start <= it.fstart;
		button_mask <= it.mask;
		left_x <= it.axis[0];
		left_y <= it.axis[1];
		right_x <= it.axis[2];
		right_y <= it.axis[3];
		do @(posedge clk); while (!in_ready);
		expected_reports.push_back(compute_pad_report(it));
	endtask

	// Stop offering items and wait until every report has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one configuration register; the block is idle here.
	task automatic write_reg(gpeh_pkg::cfg_idx_t idx, logic [gpeh_pkg::THR_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			gpeh_pkg::CFG_DEADZONE: reg_deadzone = value;
			gpeh_pkg::CFG_PRESS:    reg_press = value;
			default:                reg_release = value;
		endcase
	endtask

	// Drain, then program all three thresholds.
	task automatic write_thresholds(logic [gpeh_pkg::THR_W-1:0] dz,
		logic [gpeh_pkg::THR_W-1:0] pt, logic [gpeh_pkg::THR_W-1:0] rt);
		wait_drained();
		write_reg(gpeh_pkg::CFG_DEADZONE, dz);
		write_reg(gpeh_pkg::CFG_PRESS, pt);
		write_reg(gpeh_pkg::CFG_RELEASE, rt);
	endtask

	// Print one mismatch line, up to a cap, and count it.
	task automatic report_error(string what, longint unsigned got, longint unsigned want_v);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("mismatch at cycle %0d: %s got %0h expected %0h",
				cycle_count, what, got, want_v);
		end
	endtask

	// Compare every accepted report with the oldest predicted one.
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				report_error("report with no item pending", 0, 0);
			end else begin
				want = expected_reports.pop_front();
				if (buttons_held !== want.held)
					report_error("buttons_held", buttons_held, want.held);
				if (buttons_pressed !== want.pressed)
					report_error("buttons_pressed", buttons_pressed, want.pressed);
				if (buttons_released !== want.released)
					report_error("buttons_released", buttons_released, want.released);
				if (stick_held !== want.s_held)
					report_error("stick_held", stick_held, want.s_held);
				if (stick_down_edge !== want.s_pressed)
					report_error("stick_down_edge", stick_down_edge, want.s_pressed);
				if (stick_up_edge !== want.s_released)
					report_error("stick_up_edge", stick_up_edge, want.s_released);
				if (frame_first_button !== want.first_btn)
					report_error("frame_first_button", frame_first_button, want.first_btn);
				if (frame_first_valid !== want.first_vld)
					report_error("frame_first_valid", frame_first_valid, want.first_vld);
			end
		end
	end

	// Result side: random stalls, plus one long hold-off when a test asks for it.
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Reset thresholds: extremes of buttons and sticks, boundaries, clears, frame latch.
	task automatic test_default_thresholds();
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 0, 1, 16'h0000, 0, 0, 0, 0));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 0, 0, 16'hFFFF, -32768, 32767, 32767, -32768));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 0, 0, 16'h0000, 0, 0, 0, 0));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 1, 0, 16'h8000, 0, 0, 0, 0));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 2, 1, 16'h8000, 0, 0, 0, 0));
		// At and just below the press threshold on the negative side, just above and just below on the positive side.
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 3, 0, 16'h0010, 16384, -16384, 16383, -16383));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 3, 0, 16'h0010, -16384, 16384, -16384, 16384));
		// Around the release threshold while directions are down.
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 3, 0, 16'h0000, 13107, 13107, -13107, -13108));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 3, 0, 16'h0000, 13106, 13108, -13107, -13108));
		// Around the deadzone edge.
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 4, 1, 16'h0001, 4914, 4915, -4915, -4916));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 0, 0, 16'hFFFF, 32767, 32767, 32767, 32767));
		send_poll(make_poll(gpeh_pkg::CMD_CLEAR, 0, 0, 16'hFFFF, 32767, 32767, 32767, 32767));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 0, 0, 16'hFFFF, 32767, 32767, 32767, 32767));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 7, 0, 16'h0001, -1, 1, 0, -32768));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 7, 0, 16'hFFFF, -1, 1, 0, -32768));
		send_poll(make_poll(gpeh_pkg::CMD_CLEAR, 7, 1, 16'h0000, 0, 0, 0, 0));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 7, 0, 16'hFFFF, 0, 0, 0, 0));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 5, 0, 16'hAAAA, 20000, -20000, 20000, -20000));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 5, 1, 16'h5555, -20000, 20000, -20000, 20000));
		send_poll(make_poll(gpeh_pkg::CMD_POLL, 6, 0, 16'h0100, 0, 0, 0, 0));
	endtask

	// Extreme threshold settings: zero press, full scale, past full scale, release over press.
	task automatic test_threshold_extremes();
		logic [gpeh_pkg::THR_W-1:0] settings [6][3] = '{
			'{16'd0,     16'd0,     16'd0},
			'{16'd0,     16'd32768, 16'd32768},
			'{16'd32768, 16'd16384, 16'd13107},
			'{16'd65535, 16'd65535, 16'd65535},
			'{16'd100,   16'd8000,  16'd20000},
			'{16'd4915,  16'd16384, 16'd0}
		};
		for (int s = 0; s < 6; s++) begin
			write_thresholds(settings[s][0], settings[s][1], settings[s][2]);
			send_poll(make_poll(gpeh_pkg::CMD_POLL, 0, 1, 16'h0000, 0, 0, 0, 0));
			send_poll(make_poll(gpeh_pkg::CMD_POLL, 0, 0, 16'h0000, 0, 0, 0, 0));
			send_poll(make_poll(gpeh_pkg::CMD_POLL, 1, 0, 16'h0000,
				-32768, 32767, -32768, 32767));
			send_poll(make_poll(gpeh_pkg::CMD_POLL, 1, 0, 16'h0000, 0, 0, 0, 0));
			repeat (20) send_poll(random_poll($urandom_range(0, PADS - 1), $urandom_range(0, 1)));
		end
		write_thresholds(DEADZONE_RESET, PRESS_RESET, RELEASE_RESET);
	endtask

	// Long result hold-off while items keep coming, then a full pause on the input.
	task automatic test_backpressure();
		no_idle = 1'b1;
		@(posedge clk);
		hold_off_req = 1'b1;
		for (int i = 0; i < 40; i++) begin
			send_poll(random_poll(i % PADS, (i % PADS) == 0));
		end
		no_idle = 1'b0;
		wait_drained();
		for (int i = 0; i < 20; i++) begin
			send_poll(random_poll(i % PADS, (i % PADS) == 0));
		end
	endtask

	// Random frames of consecutive pads, with some broken frames and regular reprogramming.
	task automatic test_random_frames();
		int sent;
		int next_reprogram;
		int pads;
		int start;
		bit broken;
		sent = 0;
		next_reprogram = REPROGRAM_EVERY;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= next_reprogram) begin
				no_idle = 1'b0;
				write_thresholds(random_level(12000), random_level(32768), random_level(32768));
				next_reprogram += REPROGRAM_EVERY;
			end
			no_idle = ($urandom_range(0, 7) == 0);
			broken = ($urandom_range(0, 9) == 0);
			pads = $urandom_range(1, PADS);
			start = $urandom_range(0, PADS - 1);
			for (int i = 0; i < pads; i++) begin
				if (broken) begin
					send_poll(random_poll($urandom_range(0, PADS - 1), $urandom_range(0, 1)));
				end else begin
					send_poll(random_poll((start + i) % PADS, i == 0));
				end
				sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = gpeh_pkg::CFG_DEADZONE;
		cfg_data = '0;
		in_valid = 1'b0;
		command = gpeh_pkg::CMD_POLL;
		pad_index = '0;
		frame_start = 1'b0;
		button_mask = '0;
		left_x = '0;
		left_y = '0;
		right_x = '0;
		right_y = '0;
		out_ready = 1'b0;
		hold_off_req = 1'b0;
		no_idle = 1'b0;
		error_count = 0;
		foreach (pad_held_state[i]) begin
			pad_held_state[i] = '0;
			pad_stick_state[i] = '0;
			sent_mask[i] = '0;
		end
		frame_first_btn = '0;
		frame_first_seen = 1'b0;
		reg_deadzone = DEADZONE_RESET;
		reg_press = PRESS_RESET;
		reg_release = RELEASE_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_thresholds();
		test_threshold_extremes();
		test_backpressure();
		test_random_frames();

		wait_drained();
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/gpeh_pkg.sv
hw/rtl/gpeh_pad_state.sv
hw/rtl/gpeh_stick_eval.sv
hw/rtl/gamepad_edge_hysteresis.sv
hw/rtl/gpeh_checker.sv
bench/testbench.sv
